>>> rtl/imu_frame_deframer_unit_defines.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IMU_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Checked on every rising edge, quiet while reset is high
`define IMU_DFR_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included
`define IMU_DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/imu_dfr_pkg.sv
// Shared types and constants for the IMU frame deframer.
// No dependencies; used by imu_dfr_core, imu_dfr_outq and the top level.
package imu_dfr_pkg;

   localparam int unsigned FrameLast    = 22;  // position of the checksum byte
   localparam int unsigned PayloadFirst = 2;   // first payload byte position
   localparam int unsigned PayloadLen   = 20;  // payload bytes per frame
   localparam int unsigned WordCount    = PayloadLen / 2;
   localparam int unsigned WordWidth    = 16;
   localparam int unsigned IndexWidth   = 5;

   // Configuration register indexes
   localparam logic CSR_HEADER_FIRST  = 1'b0;
   localparam logic CSR_HEADER_SECOND = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT1   = 2'd0,
      PH_HUNT2   = 2'd1,
      PH_COLLECT = 2'd2
   } phase_type;

   // One decoded frame: words low first, then the checksum flag
   typedef struct packed {
      logic                                 checksum_good;
      logic [WordCount-1:0][WordWidth-1:0]  words;
   } result_type;

endpackage

>>> rtl/imu_frame_deframer_unit.sv
// IMU frame deframer, top level.
// Channels: req_ carries one received serial byte per transaction in
// req_tdata[7:0]. rsp_ carries one decoded frame per transaction: ten
// little-endian signed 16-bit words in rsp_tdata and the checksum flag in
// rsp_tuser. The words are zero whenever the flag is low.
// Headers are set through csr_we / csr_index / csr_wdata (index 0 first
// header byte, index 1 second header byte), to be written while the block is idle;
// the block does not enforce this. Each byte is handled in the cycle it is accepted;
// a frame's result is registered into the result queue's head, or into its skid slot
// while the head is held. One byte per cycle is taken while req_tready is high.
// Reset (synchronous, active high) clears both headers to zero, restarts the
// header hunt and empties the result queue.
// When the receiver stalls, up to two results are held (head plus skid
// slot); req_tready drops only when both are occupied, which needs the
// receiver to hold off for longer than a whole frame.

module imu_frame_deframer_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // [7:0] rx_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,    // accel_x, accel_y, accel_z, rate_x, rate_y,
                                       // rate_z, angle_roll, angle_pitch, angle_yaw,
                                       // temperature; 16 bits each from bit 0 up
   output logic          rsp_tuser,    // [0] checksum_good
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   logic                     accept;
   logic                     res_valid;
   logic                     room;
   imu_dfr_pkg::result_type  res_data;
   imu_dfr_pkg::result_type  out_data;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   imu_dfr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   imu_dfr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.words;
   assign rsp_tuser = out_data.checksum_good;

endmodule

>>> rtl/imu_dfr_core.sv
// Header hunt, payload capture and checksum for the IMU frame deframer.
// Depends on imu_dfr_pkg and imu_frame_deframer_unit_defines.svh.
`include "imu_frame_deframer_unit_defines.svh"

module imu_dfr_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_accept,
   input  logic [7:0]               in_byte,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [7:0]               csr_wdata,
   output logic                     res_valid,
   output imu_dfr_pkg::result_type  res_data
);

   imu_dfr_pkg::phase_type                 phase_ff, phase_in;
   logic [imu_dfr_pkg::IndexWidth-1:0]     byte_index_ff, byte_index_in;
   logic [7:0]                             sum_ff, sum_in;
   logic [7:0]                             header_first_ff, header_second_ff;
   logic [7:0]                             store_ff [imu_dfr_pkg::PayloadLen];
   logic                                   store_shift;
   logic                                   good;

   localparam logic [imu_dfr_pkg::IndexWidth-1:0] IdxLast  =
      imu_dfr_pkg::IndexWidth'(imu_dfr_pkg::FrameLast);
   localparam logic [imu_dfr_pkg::IndexWidth-1:0] IdxFirst =
      imu_dfr_pkg::IndexWidth'(imu_dfr_pkg::PayloadFirst);

   // Header registers, to be written only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= '0;
         header_second_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            imu_dfr_pkg::CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata;
            imu_dfr_pkg::CSR_HEADER_SECOND: header_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= imu_dfr_pkg::PH_HUNT1;
         byte_index_ff <= '0;
         sum_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         sum_ff        <= sum_in;
      end
   end

   assign good = (~sum_ff == in_byte);

   // Next state and result strobe
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      sum_in        = sum_ff;
      store_shift   = 1'b0;
      res_valid     = 1'b0;
      if (in_accept) begin
         case (phase_ff)
            imu_dfr_pkg::PH_HUNT2: begin
               if (in_byte == header_second_ff) begin
                  phase_in      = imu_dfr_pkg::PH_COLLECT;
                  byte_index_in = IdxFirst;
                  sum_in        = '0;
               end else if (in_byte != header_first_ff) begin
                  phase_in = imu_dfr_pkg::PH_HUNT1;
               end
            end
            imu_dfr_pkg::PH_COLLECT: begin
               if (byte_index_ff < IdxLast) begin
                  store_shift   = 1'b1;
                  sum_in        = sum_ff + in_byte;
                  byte_index_in = byte_index_ff + 1'b1;
               end else begin
                  res_valid     = 1'b1;
                  phase_in      = imu_dfr_pkg::PH_HUNT1;
                  byte_index_in = '0;
                  sum_in        = '0;
               end
            end
            default: begin
               phase_in = (in_byte == header_first_ff) ? imu_dfr_pkg::PH_HUNT2
                                                         : imu_dfr_pkg::PH_HUNT1;
            end
         endcase
      end
   end

   // Payload shift line: after 20 bytes, entry 0 holds frame byte 2
   always_ff @(posedge clock) begin
      if (store_shift) begin
         for (int i = 0; i < imu_dfr_pkg::PayloadLen - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[imu_dfr_pkg::PayloadLen-1] <= in_byte;
      end
   end

   // Little-endian words, zeroed on a bad checksum
   always_comb begin
      res_data.checksum_good = good;
      for (int k = 0; k < imu_dfr_pkg::WordCount; k++) begin
         res_data.words[k] = good ? {store_ff[2*k+1], store_ff[2*k]} : '0;
      end
   end

   `IMU_DFR_ASSERT_RST(a_index_in_frame, clock, reset,
      phase_ff == imu_dfr_pkg::PH_COLLECT |-> byte_index_ff >= IdxFirst && byte_index_ff <= IdxLast,
      "byte index outside the frame while collecting")
   `IMU_DFR_ASSERT_RST(a_restart_after_result, clock, reset,
      res_valid |=> phase_ff == imu_dfr_pkg::PH_HUNT1 && sum_ff == 8'd0,
      "hunt did not restart after a frame")
   `IMU_DFR_ASSERT_RST(a_index_idle, clock, reset,
      phase_ff != imu_dfr_pkg::PH_COLLECT |-> byte_index_ff == '0,
      "byte index not cleared outside a frame")

endmodule

>>> rtl/imu_dfr_outq.sv
// Two-entry result register with skid slot for the IMU frame deframer.
// Depends on imu_dfr_pkg and imu_frame_deframer_unit_defines.svh.
`include "imu_frame_deframer_unit_defines.svh"

module imu_dfr_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  imu_dfr_pkg::result_type  push_data,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output imu_dfr_pkg::result_type  out_data
);

   logic                     main_v_ff, main_v_in;
   logic                     skid_v_ff, skid_v_in;
   imu_dfr_pkg::result_type  main_ff, main_in;
   imu_dfr_pkg::result_type  skid_ff, skid_in;
   logic                     pop;

   assign pop       = main_v_ff && out_ready;
   assign room      = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   // Refill the head from the skid slot or the new result
   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (pop || !main_v_ff) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = push;
            main_in   = push_data;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `IMU_DFR_ASSERT_RST(a_skid_behind_main, clock, reset,
      skid_v_ff |-> main_v_ff,
      "skid slot holds a result while the head is empty")
   `IMU_DFR_ASSERT_RST(a_no_push_when_full, clock, reset,
      push |-> !skid_v_ff,
      "result pushed into a full queue")
   `IMU_DFR_ASSERT_RST(a_skid_moves_up, clock, reset,
      pop && skid_v_ff |=> main_v_ff && !skid_v_ff,
      "skid result not moved to the head after a transaction")

endmodule
